/* rtl/core/dtha_pkg.sv */
// Shared types, constants and helper functions of the descriptor table heap allocator.
// No dependencies; used by dtha_seq and descriptor_table_heap_allocator.
`default_nettype none

package dtha_pkg;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] operand_a;
    } t_in;

    typedef struct packed {
        logic [31:0] result_word;
        logic        status;
    } t_out;

    typedef struct packed {
        logic        reserve_enable;
        logic [15:0] reserve_units;
        logic [3:0]  block_shift;
        logic [15:0] round_mask;
    } t_cfg;

    localparam logic [1:0] FUNC_INIT  = 2'd0;
    localparam logic [1:0] FUNC_ALLOC = 2'd1;
    localparam logic [1:0] FUNC_FREE  = 2'd2;
    localparam logic [1:0] FUNC_MAINT = 2'd3;

    localparam logic [1:0] CFG_RESERVE_ENABLE = 2'd0;
    localparam logic [1:0] CFG_RESERVE_UNITS  = 2'd1;
    localparam logic [1:0] CFG_BLOCK_SHIFT    = 2'd2;
    localparam logic [1:0] CFG_ROUND_MASK     = 2'd3;

    localparam logic [31:0] ADDR_MASK = 32'h0fff_ffff;
    localparam logic [31:0] TAIL_BIT  = 32'h4000_0000;
    localparam logic [31:0] FREE_BIT  = 32'h8000_0000;
    localparam logic [31:0] DEL_WORD  = 32'h2fff_ffff;
    localparam logic [31:0] HEAP_BASE = 32'h0000_1010;
    localparam logic [31:0] HEAP_UNIT = 32'h0001_0000;
    localparam logic [31:0] FAIL_WORD = 32'hffff_ffff;

    function automatic logic sge(input logic [31:0] a, input logic [31:0] b);
        return $signed(a) >= $signed(b);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/dtha_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module dtha_ram #(
    parameter int W = 32,
    parameter int D = 257
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/dtha_seq.sv */
// Sequencer and datapath of the allocator: init, allocate, free and maintenance
// walks over the descriptor memories. Depends on dtha_pkg and dtha_ram.
`default_nettype none

module dtha_seq #(
    parameter int MAX_DESCRIPTORS = 256
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire dtha_pkg::t_in i_item,
    input  wire dtha_pkg::t_cfg i_cfg,
    input  wire logic          i_out_free,
    output logic               o_busy,
    output logic               o_done,
    output dtha_pkg::t_out     o_res
);
    import dtha_pkg::*;

    localparam int DEPTH = MAX_DESCRIPTORS + 1;
    localparam int AW = $clog2(DEPTH);
    localparam logic [31:0] DEPTH32 = 32'(DEPTH);

    localparam logic [5:0] ST_CLR   = 6'd0;
    localparam logic [5:0] ST_IDLE  = 6'd1;
    localparam logic [5:0] ST_INIT  = 6'd2;
    localparam logic [5:0] ST_A0    = 6'd3;
    localparam logic [5:0] ST_A1    = 6'd4;
    localparam logic [5:0] ST_ASRCH = 6'd5;
    localparam logic [5:0] ST_ASR   = 6'd6;
    localparam logic [5:0] ST_ASQ   = 6'd7;
    localparam logic [5:0] ST_AL    = 6'd8;
    localparam logic [5:0] ST_ALQ   = 6'd9;
    localparam logic [5:0] ST_AT1   = 6'd10;
    localparam logic [5:0] ST_AT2   = 6'd11;
    localparam logic [5:0] ST_AF1   = 6'd12;
    localparam logic [5:0] ST_AF2   = 6'd13;
    localparam logic [5:0] ST_AF3   = 6'd14;
    localparam logic [5:0] ST_AR    = 6'd15;
    localparam logic [5:0] ST_ARQ   = 6'd16;
    localparam logic [5:0] ST_AFIN  = 6'd17;
    localparam logic [5:0] ST_AFQ   = 6'd18;
    localparam logic [5:0] ST_FR    = 6'd19;
    localparam logic [5:0] ST_FQ    = 6'd20;
    localparam logic [5:0] ST_M0    = 6'd21;
    localparam logic [5:0] ST_M1    = 6'd22;
    localparam logic [5:0] ST_M2    = 6'd23;
    localparam logic [5:0] ST_M3    = 6'd24;
    localparam logic [5:0] ST_M4    = 6'd25;
    localparam logic [5:0] ST_MN    = 6'd26;
    localparam logic [5:0] ST_D0    = 6'd27;
    localparam logic [5:0] ST_D1    = 6'd28;
    localparam logic [5:0] ST_D2    = 6'd29;
    localparam logic [5:0] ST_S0    = 6'd30;
    localparam logic [5:0] ST_S1    = 6'd31;
    localparam logic [5:0] ST_S2    = 6'd32;
    localparam logic [5:0] ST_S3    = 6'd33;
    localparam logic [5:0] ST_S4    = 6'd34;
    localparam logic [5:0] ST_S5    = 6'd35;
    localparam logic [5:0] ST_SN    = 6'd36;
    localparam logic [5:0] ST_R0    = 6'd37;
    localparam logic [5:0] ST_R1    = 6'd38;
    localparam logic [5:0] ST_R2    = 6'd39;
    localparam logic [5:0] ST_R3    = 6'd40;
    localparam logic [5:0] ST_R4    = 6'd41;
    localparam logic [5:0] ST_F0    = 6'd42;
    localparam logic [5:0] ST_F1    = 6'd43;
    localparam logic [5:0] ST_F2    = 6'd44;
    localparam logic [5:0] ST_F3    = 6'd45;
    localparam logic [5:0] ST_F4    = 6'd46;
    localparam logic [5:0] ST_MRET  = 6'd47;
    localparam logic [5:0] ST_DONE  = 6'd48;

    localparam logic [1:0] RET_SEARCH = 2'd0;
    localparam logic [1:0] RET_FIN    = 2'd1;
    localparam logic [1:0] RET_DONE   = 2'd2;

    function automatic logic oob(input logic [31:0] x);
        return x >= DEPTH32;
    endfunction

    logic [5:0]  r_state, n_state;
    logic [1:0]  r_ret, n_ret;
    logic        r_fault, n_fault;
    logic [31:0] r_last, n_last;
    logic [31:0] r_limit, n_limit;
    logic [31:0] r_idx, n_idx;
    logic [31:0] r_ni, n_ni;
    logic [31:0] r_sel, n_sel;
    logic [31:0] r_a, n_a;
    logic [31:0] r_round, n_round;
    logic [31:0] r_resv, n_resv;
    logic [31:0] r_w, n_w;
    logic [31:0] r_sz, n_sz;
    logic [31:0] r_nw, n_nw;
    logic [31:0] r_ns, n_ns;
    logic [31:0] r_ow, n_ow;
    logic [31:0] r_os, n_os;
    logic [31:0] r_val, n_val;

    logic [31:0] rd_idx;
    logic        ww_en, ws_en;
    logic [31:0] ww_idx, ws_idx, ww_data, ws_data;
    logic [31:0] qw, qs;

    logic [31:0] req, mask32, rnd, gran;

    dtha_ram #(.W(32), .D(DEPTH)) u_words (
        .i_clk   (i_clk),
        .i_we    (ww_en),
        .i_waddr (ww_idx[AW-1:0]),
        .i_wdata (ww_data),
        .i_raddr (rd_idx[AW-1:0]),
        .o_rdata (qw)
    );

    dtha_ram #(.W(32), .D(DEPTH)) u_sizes (
        .i_clk   (i_clk),
        .i_we    (ws_en),
        .i_waddr (ws_idx[AW-1:0]),
        .i_wdata (ws_data),
        .i_raddr (rd_idx[AW-1:0]),
        .o_rdata (qs)
    );

    // request rounding and granule truncation
    always_comb begin
        req    = i_item.operand_a;
        mask32 = {16'b0, i_cfg.round_mask};
        gran   = ~((32'd1 << i_cfg.block_shift) - 32'd1);
        rnd    = ((req & ~mask32) != 32'd0) ? (req + mask32) : req;
        rnd    = rnd & gran;
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_fault = r_fault;
        n_last  = r_last;
        n_limit = r_limit;
        n_idx   = r_idx;
        n_ni    = r_ni;
        n_sel   = r_sel;
        n_a     = r_a;
        n_round = r_round;
        n_resv  = r_resv;
        n_w     = r_w;
        n_sz    = r_sz;
        n_nw    = r_nw;
        n_ns    = r_ns;
        n_ow    = r_ow;
        n_os    = r_os;
        n_val   = r_val;
        rd_idx  = r_idx;
        ww_en   = 1'b0;
        ws_en   = 1'b0;
        ww_idx  = r_idx;
        ws_idx  = r_idx;
        ww_data = 32'd0;
        ws_data = 32'd0;
        o_done  = 1'b0;

        case (r_state)
            ST_CLR: begin
                ww_en = 1'b1;
                ws_en = 1'b1;
                if (r_idx == DEPTH32 - 32'd1) begin
                    n_idx   = 32'd0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + 32'd1;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_fault = 1'b0;
                    n_a     = i_item.operand_a;
                    n_round = rnd;
                    n_resv  = i_cfg.reserve_enable ?
                        ((HEAP_UNIT - {16'b0, i_cfg.reserve_units}) << i_cfg.block_shift)
                        : 32'd0;
                    n_ret   = RET_DONE;
                    case (i_item.func)
                        FUNC_INIT:  n_state = ST_INIT;
                        FUNC_ALLOC: n_state = ST_A0;
                        FUNC_FREE: begin
                            n_idx   = 32'd0;
                            n_state = sge(r_limit, 32'd1) ? ST_FR : ST_M0;
                        end
                        default:    n_state = ST_M0;
                    endcase
                end
            end
            ST_INIT: begin
                n_state = ST_DONE;
                if (!sge(r_a, 32'd1)) begin
                    n_val = 32'd0;
                end else begin
                    ww_en   = 1'b1;
                    ws_en   = 1'b1;
                    ww_idx  = 32'd0;
                    ws_idx  = 32'd0;
                    ww_data = TAIL_BIT | HEAP_BASE;
                    ws_data = (HEAP_UNIT << i_cfg.block_shift) - HEAP_BASE;
                    n_last  = 32'd0;
                    n_limit = r_a;
                    n_val   = r_a;
                end
            end
            ST_A0: begin
                rd_idx  = 32'd0;
                n_state = ST_A1;
            end
            ST_A1: begin
                if ((qw & TAIL_BIT) != 32'd0) begin
                    n_sel   = 32'd0;
                    n_state = ST_AL;
                end else begin
                    n_ret   = RET_SEARCH;
                    n_state = ST_M0;
                end
            end
            ST_ASRCH: begin
                n_idx = 32'd0;
                if (sge(r_limit, 32'd1)) begin
                    n_state = ST_ASR;
                end else begin
                    n_val   = FAIL_WORD;
                    n_state = ST_DONE;
                end
            end
            ST_ASR: begin
                if (oob(r_idx)) begin
                    n_fault = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_ASQ;
                end
            end
            ST_ASQ: begin
                if (((qw & TAIL_BIT) != 32'd0) ||
                    (((qw & FREE_BIT) != 32'd0) && (qs >= r_round))) begin
                    n_sel   = r_idx;
                    n_state = ST_AL;
                end else begin
                    n_idx = r_idx + 32'd1;
                    if (!sge(r_idx + 32'd1, r_limit)) begin
                        n_state = ST_ASR;
                    end else begin
                        n_val   = FAIL_WORD;
                        n_state = ST_DONE;
                    end
                end
            end
            ST_AL: begin
                rd_idx  = r_sel;
                n_state = ST_ALQ;
            end
            ST_ALQ: begin
                n_w  = qw;
                n_sz = qs;
                if ((qw & TAIL_BIT) != 32'd0) begin
                    if (sge(r_sel, r_limit) || ((qs - r_resv) < r_round)) begin
                        n_val   = FAIL_WORD;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_AT1;
                    end
                end else if ((r_round < qs) && !sge(r_last, r_limit)) begin
                    n_state = ST_AF1;
                end else begin
                    n_state = ST_AR;
                end
            end
            ST_AT1: begin
                if (oob(r_sel + 32'd1)) begin
                    n_fault = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    ww_en   = 1'b1;
                    ws_en   = 1'b1;
                    ww_idx  = r_sel + 32'd1;
                    ws_idx  = r_sel + 32'd1;
                    ww_data = ((r_w & ADDR_MASK) + r_round) | TAIL_BIT;
                    ws_data = r_sz - r_round;
                    n_state = ST_AT2;
                end
            end
            ST_AT2: begin
                n_last  = r_sel + 32'd1;
                ww_en   = 1'b1;
                ws_en   = 1'b1;
                ww_idx  = r_sel;
                ws_idx  = r_sel;
                ww_data = r_w & ADDR_MASK;
                ws_data = r_round;
                n_ret   = RET_FIN;
                n_state = ST_M0;
            end
            ST_AF1: begin
                rd_idx = r_last;
                if (oob(r_last)) begin
                    n_fault = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_AF2;
                end
            end
            ST_AF2: begin
                n_nw    = qw;
                n_ns    = qs;
                ww_en   = 1'b1;
                ws_en   = 1'b1;
                ww_idx  = r_last;
                ws_idx  = r_last;
                ww_data = (r_round + r_w) | FREE_BIT;
                ws_data = r_sz - r_round;
                n_state = ST_AF3;
            end
            ST_AF3: begin
                n_last = r_last + 32'd1;
                if (oob(r_last + 32'd1)) begin
                    n_fault = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    ww_en   = 1'b1;
                    ws_en   = 1'b1;
                    ww_idx  = r_last + 32'd1;
                    ws_idx  = r_last + 32'd1;
                    ww_data = r_nw;
                    ws_data = r_ns;
                    n_state = ST_AR;
                end
            end
            ST_AR: begin
                rd_idx  = r_sel;
                n_state = ST_ARQ;
            end
            ST_ARQ: begin
                ww_en   = 1'b1;
                ws_en   = 1'b1;
                ww_idx  = r_sel;
                ws_idx  = r_sel;
                ww_data = qw & ADDR_MASK;
                ws_data = r_round;
                n_ret   = RET_FIN;
                n_state = ST_M0;
            end
            ST_AFIN: begin
                rd_idx  = r_sel;
                n_state = ST_AFQ;
            end
            ST_AFQ: begin
                n_val   = qw;
                n_state = ST_DONE;
            end
            ST_FR: begin
                if (oob(r_idx)) begin
                    n_fault = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_FQ;
                end
            end
            ST_FQ: begin
                if ((qw & TAIL_BIT) != 32'd0) begin
                    n_state = ST_M0;
                end else if (qw == r_a) begin
                    ww_en   = 1'b1;
                    ww_data = r_a | FREE_BIT;
                    n_state = ST_M0;
                end else begin
                    n_idx   = r_idx + 32'd1;
                    n_state = !sge(r_idx + 32'd1, r_limit) ? ST_FR : ST_M0;
                end
            end
            // merge adjacent free blocks
            ST_M0: begin
                n_idx   = 32'd0;
                n_state = sge(r_last, 32'd0) ? ST_M1 : ST_D0;
            end
            ST_M1: begin
                if (oob(r_idx)) begin
                    n_fault = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_M2;
                end
            end
            ST_M2: begin
                n_w  = qw;
                n_sz = qs;
                n_ni = r_idx + 32'd1;
                n_state = ((qw & FREE_BIT) != 32'd0) ? ST_M3 : ST_MN;
            end
            ST_M3: begin
                rd_idx = r_ni;
                if (oob(r_ni)) begin
                    n_fault = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_M4;
                end
            end
            ST_M4: begin
                if (qw == DEL_WORD) begin
                    n_ni    = r_ni + 32'd1;
                    n_state = ST_M3;
                end else if (((qw & FREE_BIT) != 32'd0) &&
                             ((qw & ADDR_MASK) == ((r_w & ADDR_MASK) + r_sz))) begin
                    ww_en   = 1'b1;
                    ws_en   = 1'b1;
                    ww_idx  = r_ni;
                    ww_data = DEL_WORD;
                    ws_data = r_sz + qs;
                    n_state = ST_M1;
                end else begin
                    n_state = ST_MN;
                end
            end
            ST_MN: begin
                n_idx   = r_idx + 32'd1;
                n_state = sge(r_last, r_idx + 32'd1) ? ST_M1 : ST_D0;
            end
            // delete zero-size blocks
            ST_D0: begin
                n_idx   = 32'd0;
                n_state = sge(r_last, 32'd0) ? ST_D1 : ST_S0;
            end
            ST_D1: begin
                if (oob(r_idx)) begin
                    n_fault = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_D2;
                end
            end
            ST_D2: begin
                ww_en   = (qs == 32'd0);
                ww_data = DEL_WORD;
                n_idx   = r_idx + 32'd1;
                n_state = sge(r_last, r_idx + 32'd1) ? ST_D1 : ST_S0;
            end
            // sort by address
            ST_S0: begin
                n_idx   = 32'd0;
                n_state = sge(r_last, 32'd0) ? ST_S1 : ST_R0;
            end
            ST_S1: begin
                if (oob(r_idx)) begin
                    n_fault = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_S2;
                end
            end
            ST_S2: begin
                n_ow = qw;
                n_os = qs;
                n_ni = r_idx + 32'd1;
                if ((qw & TAIL_BIT) != 32'd0) begin
                    n_state = ST_R0;
                end else begin
                    n_state = sge(r_last, r_idx + 32'd1) ? ST_S3 : ST_SN;
                end
            end
            ST_S3: begin
                rd_idx = r_ni;
                if (oob(r_ni)) begin
                    n_fault = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_S4;
                end
            end
            ST_S4: begin
                if ((qw & TAIL_BIT) != 32'd0) begin
                    n_state = ST_SN;
                end else if ((qw & ADDR_MASK) < (r_ow & ADDR_MASK)) begin
                    ww_en   = 1'b1;
                    ws_en   = 1'b1;
                    ww_data = qw;
                    ws_data = qs;
                    n_nw    = r_ow;
                    n_ns    = r_os;
                    n_ow    = qw;
                    n_os    = qs;
                    n_state = ST_S5;
                end else begin
                    n_ni    = r_ni + 32'd1;
                    n_state = sge(r_last, r_ni + 32'd1) ? ST_S3 : ST_SN;
                end
            end
            ST_S5: begin
                ww_en   = 1'b1;
                ws_en   = 1'b1;
                ww_idx  = r_ni;
                ws_idx  = r_ni;
                ww_data = r_nw;
                ws_data = r_ns;
                n_ni    = r_ni + 32'd1;
                n_state = sge(r_last, r_ni + 32'd1) ? ST_S3 : ST_SN;
            end
            ST_SN: begin
                n_idx   = r_idx + 32'd1;
                n_state = sge(r_last, r_idx + 32'd1) ? ST_S1 : ST_R0;
            end
            // refill first deleted slot from the last entry
            ST_R0: begin
                n_idx   = 32'd0;
                n_state = sge(r_last, 32'd0) ? ST_R1 : ST_F0;
            end
            ST_R1: begin
                if (oob(r_idx)) begin
                    n_fault = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_R2;
                end
            end
            ST_R2: begin
                if ((qw & TAIL_BIT) != 32'd0) begin
                    n_state = ST_F0;
                end else if (qw == DEL_WORD) begin
                    n_state = ST_R3;
                end else begin
                    n_idx   = r_idx + 32'd1;
                    n_state = sge(r_last, r_idx + 32'd1) ? ST_R1 : ST_F0;
                end
            end
            ST_R3: begin
                rd_idx = r_last;
                if (oob(r_last)) begin
                    n_fault = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_R4;
                end
            end
            ST_R4: begin
                ww_en   = 1'b1;
                ws_en   = 1'b1;
                ww_data = qw;
                ws_data = qs;
                n_last  = r_idx;
                n_state = ST_F0;
            end
            // fold trailing free blocks into the tail
            ST_F0: begin
                n_idx   = r_last - 32'd1;
                n_val   = (r_last - 32'd1) << 3;
                n_state = sge(r_last - 32'd1, 32'd0) ? ST_F1 : ST_MRET;
            end
            ST_F1: begin
                if (oob(r_idx)) begin
                    n_fault = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_F2;
                end
            end
            ST_F2: begin
                n_val = qw & ADDR_MASK;
                if ((qw & FREE_BIT) == 32'd0) begin
                    n_state = ST_MRET;
                end else begin
                    ww_en   = 1'b1;
                    ww_data = (qw & ADDR_MASK) | TAIL_BIT;
                    n_sz    = qs;
                    n_ni    = r_last;
                    n_last  = r_idx;
                    n_state = ST_F3;
                end
            end
            ST_F3: begin
                rd_idx = r_ni;
                if (oob(r_ni)) begin
                    n_fault = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_F4;
                end
            end
            ST_F4: begin
                ws_en   = 1'b1;
                ws_data = r_sz + qs;
                n_val   = r_sz + qs;
                n_idx   = r_idx - 32'd1;
                n_state = sge(r_idx - 32'd1, 32'd0) ? ST_F1 : ST_MRET;
            end
            ST_MRET: begin
                case (r_ret)
                    RET_SEARCH: n_state = ST_ASRCH;
                    RET_FIN:    n_state = ST_AFIN;
                    default:    n_state = ST_DONE;
                endcase
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy            = (r_state != ST_IDLE);
    assign o_res.result_word = r_fault ? 32'd0 : r_val;
    assign o_res.status      = r_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_ret   <= RET_DONE;
            r_fault <= 1'b0;
            r_last  <= 32'd0;
            r_limit <= 32'd0;
            r_idx   <= 32'd0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_fault <= n_fault;
            r_last  <= n_last;
            r_limit <= n_limit;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ni    <= n_ni;
        r_sel   <= n_sel;
        r_a     <= n_a;
        r_round <= n_round;
        r_resv  <= n_resv;
        r_w     <= n_w;
        r_sz    <= n_sz;
        r_nw    <= n_nw;
        r_ns    <= n_ns;
        r_ow    <= n_ow;
        r_os    <= n_os;
        r_val   <= n_val;
    end

endmodule

`default_nettype wire

/* rtl/core/descriptor_table_heap_allocator.sv */
// Top level of the descriptor table heap allocator: ports, configuration registers, result register.
// Depends on dtha_pkg and dtha_seq.
`default_nettype none

// First-fit heap allocator over a table of MAX_DESCRIPTORS+1 descriptors, each an address word
// (free and tail marks) and a size, held in two RAMs with one read and one write port each.
// One item at a time: allocate, free and maintain run a full maintenance walk through the
// RAMs (allocate skips it only when it fails while entry 0 is the tail), whose steps in order
// are: merge adjacent free blocks, delete zero-size blocks, sort by address, refill the first
// deleted slot from the last entry, and fold trailing free blocks into the tail. RAM read data
// is registered. After reset the block first clears both RAMs, with input stall high.
// A finished result waits in an output register while the next item is taken.
module descriptor_table_heap_allocator #(
    parameter int MAX_DESCRIPTORS = 256
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire dtha_pkg::t_in i_data,
    output logic               o_stall,
    output logic               o_valid,
    output dtha_pkg::t_out     o_data,
    input  wire logic          i_stall,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic [15:0]   i_cfg_data
);
    import dtha_pkg::*;

    t_cfg r_cfg;
    logic r_ovalid;
    t_out r_odata;
    logic busy, done, out_free;
    t_out res;

    assign out_free = !r_ovalid || !i_stall;

    dtha_seq #(.MAX_DESCRIPTORS(MAX_DESCRIPTORS)) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_valid && !busy),
        .i_item     (i_data),
        .i_cfg      (r_cfg),
        .i_out_free (out_free),
        .o_busy     (busy),
        .o_done     (done),
        .o_res      (res)
    );

    assign o_stall = busy;
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reserve_enable <= 1'b0;
            r_cfg.reserve_units  <= 16'd0;
            r_cfg.block_shift    <= 4'd3;
            r_cfg.round_mask     <= 16'd7;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RESERVE_ENABLE: r_cfg.reserve_enable <= i_cfg_data[0];
                CFG_RESERVE_UNITS:  r_cfg.reserve_units  <= i_cfg_data;
                CFG_BLOCK_SHIFT:    r_cfg.block_shift    <= i_cfg_data[3:0];
                CFG_ROUND_MASK:     r_cfg.round_mask     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (done) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_odata <= res;
        end
    end

endmodule

`default_nettype wire
